// ----- rtl/core/fps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fps_pkg: shared types and constants of the frame playback sequencer
// Request and mode codes, register indexes, beat field widths and the
// sequencer state type.
// ----------------------------------------------------------------------------
package fps_pkg;

	// beat field widths
	localparam int REQ_W       = 2;
	localparam int TICK_W      = 32;
	localparam int FRAME_OUT_W = 16;
	localparam int SKIP_OUT_W  = 16;
	localparam int SUM_W       = 32;
	localparam int WIN_CNT_W   = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_FRAME   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STATS_ENABLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STATS_WINDOW = 3'd5;

	localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = 32'd1000000;
	localparam logic [SUM_W-1:0]      SUM_MAX      = 32'hFFFF_FFFF;
	localparam logic [SKIP_OUT_W-1:0] SKIP_OUT_MAX = 16'hFFFF;

	// request codes
	localparam logic [REQ_W-1:0] REQ_START = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_EVENT = 2'd2;

	// play modes; the spare code plays forward
	localparam logic [1:0] MODE_FWD    = 2'd0;
	localparam logic [1:0] MODE_REV    = 2'd1;
	localparam logic [1:0] MODE_BOUNCE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_SUB,
		ST_STEP
	} fps_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/fps_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fps_req_if: request channel
// Valid/ready channel carrying one request beat: type and timestamp.
// ----------------------------------------------------------------------------
interface fps_req_if;
	import fps_pkg::*;

	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [TICK_W-1:0] now_ticks;

	modport source (output valid, output req_type, output now_ticks, input ready);
	modport sink   (input valid, input req_type, input now_ticks, output ready);

endinterface
`default_nettype wire

// ----- rtl/core/fps_res_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fps_res_if: result channel
// Valid/ready channel carrying one result beat per request.
// ----------------------------------------------------------------------------
interface fps_res_if;
	import fps_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [FRAME_OUT_W-1:0] frame_number;
	logic                   running;
	logic [SKIP_OUT_W-1:0]  frames_skipped;
	logic                   stats_valid;
	logic [SUM_W-1:0]       window_ticks;

	modport source (output valid, output frame_number, output running,
		output frames_skipped, output stats_valid, output window_ticks, input ready);
	modport sink   (input valid, input frame_number, input running,
		input frames_skipped, input stats_valid, input window_ticks, output ready);

endinterface
`default_nettype wire

// ----- rtl/core/frame_playback_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frame_playback_sequencer: timestamped animation frame sequencer
// Start, stop and frame-event requests step a frame counter over a range,
// with late-event frame skipping and optional interval statistics.
// ----------------------------------------------------------------------------
// Usage:
//   req  - request beats (req_type, now_ticks); one request in flight at a time,
//          ready is high only while the sequencer is idle.
//   res  - exactly one result beat per request, held in an output register.
//   cfg  - register writes (cfg_we, cfg_index, cfg_data);
//          write only while no request is in flight.
// Path: start, stop and events that skip no extra frames pass through the
//   prepare and step states. A frame event more than one period late runs
//   the skip count through the divider, one quotient bit a cycle, and then
//   a subtract state before its step.
// Flow: a new request is taken only once the last one is back in idle.
// Stall: a waiting result beat does not block acceptance; the next request
//   is worked through and parks in its final step until the output register
//   is free.
// Reset: all control and playback state cleared, registers take their reset
//   values (period 1000000 ticks, statistics window 1), sequencer stopped.
// ----------------------------------------------------------------------------
module frame_playback_sequencer #(
	parameter int TIME_WIDTH  = 32,
	parameter int FRAME_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [fps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fps_pkg::CFG_DATA_W-1:0]  cfg_data,
	fps_req_if.sink                              req,
	fps_res_if.source                            res
);
	import fps_pkg::*;

	localparam int TW  = TIME_WIDTH;
	localparam int FW  = FRAME_WIDTH;
	localparam int SKW = (TW + 1 > FW) ? TW + 1 : FW;
	localparam int SW  = ((TW > SUM_W) ? TW : SUM_W) + 1;
	localparam int VW  = FW + 2;
	localparam int OW  = (FW > SKIP_OUT_W) ? FW : SKIP_OUT_W;

	// configuration registers
	logic [FW-1:0]         first_frame_q;
	logic [FW-1:0]         last_frame_q;
	logic [1:0]            play_mode_q;
	logic [CFG_DATA_W-1:0] frame_period_q;
	logic                  stats_enable_q;
	logic [WIN_CNT_W-1:0]  stats_window_q;

	// playback state
	logic [FW-1:0]         cur_q;
	logic                  down_q;
	logic                  active_q;
	logic [TW-1:0]         last_ev_q;
	logic [TW-1:0]         due_q;
	logic [SUM_W-1:0]      sum_q;
	logic [WIN_CNT_W-1:0]  samples_q;

	// request in flight
	fps_state_t            state_q, state_d;
	logic [REQ_W-1:0]      req_q;
	logic [TW-1:0]         now_q;
	logic [TW-1:0]         err_q;
	logic [TW-1:0]         elapsed_q;
	logic [TW-1:0]         due_acc_q;
	logic                  div_q;

	// result register
	logic                   res_valid_q;
	logic [FRAME_OUT_W-1:0] res_frame_q;
	logic                   res_running_q;
	logic [SKIP_OUT_W-1:0]  res_skipped_q;
	logic                   res_stats_q;
	logic [SUM_W-1:0]       res_window_q;

	logic [TW-1:0] period_c;
	logic [TW-1:0] err_c;
	logic [TW-1:0] elapsed_c;
	logic          div_need_c;
	logic          div_start;
	logic          div_done;
	logic [TW-1:0] div_quo;
	logic [TW-1:0] div_rem;
	logic          step_fire;

	assign period_c = TW'(frame_period_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_frame_q  <= '0;
			last_frame_q   <= '0;
			play_mode_q    <= MODE_FWD;
			frame_period_q <= PERIOD_RESET;
			stats_enable_q <= 1'b0;
			stats_window_q <= WIN_CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_FRAME:  first_frame_q  <= FW'(cfg_data[FRAME_OUT_W-1:0]);
				CFG_LAST_FRAME:   last_frame_q   <= FW'(cfg_data[FRAME_OUT_W-1:0]);
				CFG_PLAY_MODE:    play_mode_q    <= cfg_data[1:0];
				CFG_FRAME_PERIOD: frame_period_q <= cfg_data;
				CFG_STATS_ENABLE: stats_enable_q <= cfg_data[0];
				CFG_STATS_WINDOW: stats_window_q <= cfg_data[WIN_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// lateness and interval, set up in the prepare step
	always_comb begin
		err_c      = now_q - due_q;
		elapsed_c  = now_q - last_ev_q;
		div_need_c = (req_q == REQ_EVENT) && active_q && !err_c[TW-1] &&
			(period_c != '0) && (err_c > period_c);
	end

	fps_div #(
		.W (TW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (err_c),
		.divisor   (period_c),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// sequencer
	assign step_fire = (state_q == ST_STEP) && (!res_valid_q || res.ready);
	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (div_need_c) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (step_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// request beat and intermediate values
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.req_type;
			now_q <= TW'(req.now_ticks);
		end
		if (state_q == ST_PREP) begin
			err_q     <= err_c;
			elapsed_q <= elapsed_c;
			due_acc_q <= ((req_q == REQ_START) ? now_q : due_q) + period_c;
		end
		// lateness minus remainder is period times the extra skip
		if (state_q == ST_SUB) begin
			err_q <= err_q - div_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= 1'b0;
		end else if (state_q == ST_PREP) begin
			div_q <= div_need_c;
		end
	end

	// skip count and frame step
	logic [SKW-1:0]        skip_c;
	logic [FW-1:0]         sk_c;
	logic [SKIP_OUT_W-1:0] skip_out_c;
	logic signed [VW-1:0]  cur_s, sk_s, lo_s, hi_s, v_c, v_lim;
	logic                  bounce_down;

	always_comb begin
		skip_c     = div_q ? (SKW'(div_quo) + SKW'(1)) : SKW'(1);
		sk_c       = (skip_c > SKW'({FW{1'b1}})) ? {FW{1'b1}} : FW'(skip_c);
		skip_out_c = (OW'(sk_c) > OW'(SKIP_OUT_MAX)) ? SKIP_OUT_MAX : SKIP_OUT_W'(sk_c);
		cur_s      = signed'(VW'(cur_q));
		sk_s       = signed'(VW'(sk_c));
		lo_s       = signed'(VW'(first_frame_q));
		hi_s       = signed'(VW'(last_frame_q));
		v_c        = down_q ? (cur_s - sk_s) : (cur_s + sk_s);
		v_lim       = v_c;
		bounce_down = down_q;
		case (play_mode_q)
			MODE_REV: begin
				if (v_lim < lo_s) begin
					v_lim = hi_s;
				end
			end
			MODE_BOUNCE: begin
				// top clamp first, then bottom; both may flip
				if (v_lim >= hi_s) begin
					v_lim       = hi_s;
					bounce_down = !bounce_down;
				end
				if (v_lim <= lo_s) begin
					v_lim       = lo_s;
					bounce_down = !bounce_down;
				end
			end
			default: begin
				if (v_lim > hi_s) begin
					v_lim = lo_s;
				end
			end
		endcase
	end

	// statistics accumulate
	logic [SW-1:0]    sum_wide_c;
	logic [SUM_W-1:0] sum_sat_c;
	logic             win_done_c;

	always_comb begin
		sum_wide_c = SW'(elapsed_q) + SW'(sum_q);
		sum_sat_c  = (sum_wide_c > SW'(SUM_MAX)) ? SUM_MAX : sum_wide_c[SUM_W-1:0];
		win_done_c = samples_q <= WIN_CNT_W'(1);
	end

	// next playback state and result fields
	logic [FW-1:0]         cur_n;
	logic                  down_n;
	logic                  active_n;
	logic [TW-1:0]         last_ev_n;
	logic [TW-1:0]         due_n;
	logic [SUM_W-1:0]      sum_n;
	logic [WIN_CNT_W-1:0]  samples_n;
	logic [SKIP_OUT_W-1:0] skipped_n;
	logic                  stats_n;
	logic [SUM_W-1:0]      window_n;

	always_comb begin
		cur_n     = cur_q;
		down_n    = down_q;
		active_n  = active_q;
		last_ev_n = last_ev_q;
		due_n     = due_q;
		sum_n     = sum_q;
		samples_n = samples_q;
		skipped_n = '0;
		stats_n   = 1'b0;
		window_n  = '0;
		case (req_q)
			REQ_START: begin
				down_n    = (play_mode_q == MODE_REV);
				cur_n     = (play_mode_q == MODE_REV) ? last_frame_q : first_frame_q;
				active_n  = 1'b1;
				last_ev_n = now_q;
				due_n     = due_acc_q;
				if (stats_enable_q) begin
					sum_n     = '0;
					samples_n = stats_window_q;
				end
			end
			REQ_STOP: begin
				active_n = 1'b0;
			end
			REQ_EVENT: begin
				if (active_q) begin
					due_n     = due_acc_q + (div_q ? err_q : '0);
					cur_n     = v_lim[FW-1:0];
					down_n    = bounce_down;
					skipped_n = skip_out_c;
					last_ev_n = now_q;
					if (stats_enable_q) begin
						if (win_done_c) begin
							stats_n   = 1'b1;
							window_n  = sum_sat_c;
							sum_n     = '0;
							samples_n = stats_window_q;
						end else begin
							sum_n     = sum_sat_c;
							samples_n = samples_q - WIN_CNT_W'(1);
						end
					end
				end
			end
			default: ;
		endcase
	end

	// playback state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			down_q    <= 1'b0;
			active_q  <= 1'b0;
			last_ev_q <= '0;
			due_q     <= '0;
			sum_q     <= '0;
			samples_q <= '0;
		end else if (step_fire) begin
			cur_q     <= cur_n;
			down_q    <= down_n;
			active_q  <= active_n;
			last_ev_q <= last_ev_n;
			due_q     <= due_n;
			sum_q     <= sum_n;
			samples_q <= samples_n;
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			res_frame_q   <= FRAME_OUT_W'(cur_n);
			res_running_q <= active_n;
			res_skipped_q <= skipped_n;
			res_stats_q   <= stats_n;
			res_window_q  <= window_n;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.frame_number   = res_frame_q;
	assign res.running        = res_running_q;
	assign res.frames_skipped = res_skipped_q;
	assign res.stats_valid    = res_stats_q;
	assign res.window_ticks   = res_window_q;

endmodule
`default_nettype wire

// ----- rtl/core/fps_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fps_div: iterative unsigned divider
// Restoring divide, one quotient bit per cycle. done pulses for one cycle
// once quotient and remainder are final; they then hold until next start.
// ----------------------------------------------------------------------------
module fps_div #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;

	logic [W:0]    shift_c;
	logic [W:0]    diff_c;
	logic          ge_c;
	logic [W-1:0]  rem_next_c;

	// one trial subtraction per cycle
	always_comb begin
		shift_c    = {rem_q, quo_q[W-1]};
		diff_c     = shift_c - {1'b0, divisor};
		ge_c       = shift_c >= {1'b0, divisor};
		rem_next_c = ge_c ? diff_c[W-1:0] : shift_c[W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next_c;
			quo_q <= {quo_q[W-2:0], ge_c};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire
